[rtl/core/rais_pkg.sv]
`default_nettype none
package rais_pkg;

  // item field widths
  localparam int IDX_W  = 16;
  localparam int ROLL_W = 32;

  // control of the sorted blocked-index list
  typedef struct packed {
    logic clear;
    logic ins;
    logic pop;
  } rais_list_ctl_t;

endpackage
`default_nettype wire

[rtl/core/rais_ram.sv]
`default_nettype none
module rais_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

[rtl/core/rais_div.sv]
`default_nettype none
module rais_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [rais_pkg::ROLL_W-1:0] dividend,
  input  wire logic [rais_pkg::IDX_W-1:0]  divisor,
  output logic                             busy,
  output logic                             done,
  output logic      [rais_pkg::IDX_W-1:0]  remainder
);
  import rais_pkg::*;

  localparam int CW = $clog2(ROLL_W);

  logic [ROLL_W-1:0] dvd_r;
  logic [IDX_W-1:0]  dsr_r;
  logic [IDX_W-1:0]  rem_r;
  logic [CW-1:0]     cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [IDX_W:0]    trial;
  logic              fits;
  logic [IDX_W:0]    diff;
  logic [IDX_W-1:0]  rem_step;

  // one restoring step: bring in the next dividend bit, subtract if it fits
  always_comb begin
    trial    = {rem_r, dvd_r[ROLL_W-1]};
    fits     = trial >= {1'b0, dsr_r};
    diff     = trial - {1'b0, dsr_r};
    rem_step = fits ? diff[IDX_W-1:0] : trial[IDX_W-1:0];
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(ROLL_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[ROLL_W-2:0], 1'b0};
      rem_r <= rem_step;
    end
  end

  assign busy      = busy_r;
  assign done      = done_r;
  assign remainder = rem_r;

endmodule
`default_nettype wire

[rtl/core/rais_sort_list.sv]
`default_nettype none
module rais_sort_list #(
  parameter int DEPTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire rais_pkg::rais_list_ctl_t      ctl,
  input  wire logic [rais_pkg::IDX_W-1:0]    ins_value,
  output logic      [rais_pkg::IDX_W-1:0]    head,
  output logic      [$clog2(DEPTH+1)-1:0]    cnt
);
  import rais_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic [IDX_W-1:0] val_r [DEPTH];
  logic [CW-1:0]    cnt_r;

  logic [DEPTH-1:0] valid;
  logic [DEPTH-1:0] eq;
  logic [DEPTH-1:0] above;
  logic [IDX_W-1:0] ins_val [DEPTH];
  logic [IDX_W-1:0] pop_val [DEPTH];
  logic             dup;
  logic             do_ins;

  // per-cell compare against the incoming value
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      valid[i] = CW'(i) < cnt_r;
      eq[i]    = valid[i] && (val_r[i] == ins_value);
      above[i] = !valid[i] || (val_r[i] > ins_value);
    end
  end

  assign dup    = |eq;
  assign do_ins = ctl.ins && !dup && (cnt_r < CW'(DEPTH));

  // insert keeps ascending order, pop shifts toward the head
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign ins_val[g] = above[g] ? ins_value : val_r[g];
    end else begin : g_rest
      assign ins_val[g] = !above[g]   ? val_r[g]  :
                          !above[g-1] ? ins_value : val_r[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign pop_val[g] = val_r[g];
    end else begin : g_mid
      assign pop_val[g] = val_r[g+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (ctl.clear) begin
      cnt_r <= '0;
    end else if (do_ins) begin
      cnt_r <= cnt_r + 1'b1;
    end else if (ctl.pop && (cnt_r != '0)) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!ctl.clear) begin
      if (do_ins) begin
        val_r <= ins_val;
      end else if (ctl.pop) begin
        val_r <= pop_val;
      end
    end
  end

  assign head = val_r[0];
  assign cnt  = cnt_r;

endmodule
`default_nettype wire

[rtl/core/recent_avoiding_index_selector.sv]
// remember: no result; ready again the next cycle
// choose: a count of at most 1, or sequential mode with no history, goes straight to the output;
//   sequential reads the last entry, then runs the shared 32-step remainder unit; shuffle scans a
//   window of W entries, runs the remainder unit, then steps past the P blocked indices
// input is not ready from a choose accept until its result enters the output register
// synchronous active-low reset clears config, control, fill and slot; history memory is not
`default_nettype none
module recent_avoiding_index_selector #(
  parameter int HISTORY_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // in_tdata: command [0], random_roll [32:1], remember_index [48:33]
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [55:0] in_tdata,
  // out_tdata: chosen_index [15:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [15:0] out_tdata,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);
  import rais_pkg::*;

  localparam int D  = HISTORY_DEPTH;
  localparam int AW = (D > 1) ? $clog2(D) : 1;
  localparam int FW = $clog2(D + 1);

  localparam logic [1:0] REG_SHUFFLE = 2'd0;
  localparam logic [1:0] REG_COUNT   = 2'd1;
  localparam logic [1:0] REG_HVALID  = 2'd2;

  localparam logic CMD_CHOOSE   = 1'b0;
  localparam logic CMD_REMEMBER = 1'b1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SEQ_RD = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DIVGO  = 3'd3;
  localparam logic [2:0] S_DIV    = 3'd4;
  localparam logic [2:0] S_STEP   = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  // configuration registers
  logic             shuffle_r;
  logic [IDX_W-1:0] count_r;
  logic             hvalid_r;

  // history state
  logic [AW-1:0]    slot_r;
  logic [FW-1:0]    fill_r;

  // sequencer
  logic [2:0]       state_r, state_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [FW-1:0]    left_r, left_nxt;
  logic             pend_r, pend_nxt;
  logic [ROLL_W-1:0] roll_r;
  logic [IDX_W:0]   rank_r, rank_nxt;
  logic [IDX_W-1:0] res_r, res_nxt;
  logic             out_valid_r;
  logic [IDX_W-1:0] out_data_r;

  logic             cfg_wr;
  logic             in_acc;
  logic             in_cmd;
  logic [ROLL_W-1:0] in_roll;
  logic [IDX_W-1:0] in_idx;
  logic [AW-1:0]    slot_prev;
  logic [AW-1:0]    ptr_prev;
  logic [IDX_W-1:0] cm1;
  logic [FW-1:0]    window;
  logic [IDX_W-1:0] ram_rdata;
  logic             ram_we;
  logic [IDX_W:0]   seq_plus1;

  rais_list_ctl_t   lst_ctl;
  logic [IDX_W-1:0] lst_head;
  logic [FW-1:0]    lst_cnt;

  logic             div_start;
  logic [ROLL_W-1:0] div_dvd;
  logic [IDX_W-1:0] div_dsr;
  logic             div_busy;
  logic             div_done;
  logic [IDX_W-1:0] div_rem;
  logic             out_load;
  logic             step_on;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shuffle_r <= 1'b0;
      count_r   <= '0;
      hvalid_r  <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_SHUFFLE: shuffle_r <= cfg_pwdata[0];
        REG_COUNT:   count_r   <= cfg_pwdata[IDX_W-1:0];
        REG_HVALID:  hvalid_r  <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_SHUFFLE: cfg_prdata = {31'b0, shuffle_r};
      REG_COUNT:   cfg_prdata = {16'b0, count_r};
      REG_HVALID:  cfg_prdata = {31'b0, hvalid_r};
      default:     cfg_prdata = '0;
    endcase
  end

  // input unpack
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_cmd    = in_tdata[0];
  assign in_roll   = in_tdata[32:1];
  assign in_idx    = in_tdata[48:33];

  // ring pointers and blocking window
  assign slot_prev = (slot_r == '0) ? AW'(D - 1) : slot_r - 1'b1;
  assign ptr_prev  = (rd_ptr_r == '0) ? AW'(D - 1) : rd_ptr_r - 1'b1;
  assign cm1       = count_r - 1'b1;
  assign window    = !hvalid_r ? '0 :
                     (cm1 < IDX_W'(fill_r)) ? cm1[FW-1:0] : fill_r;

  // history memory
  assign ram_we = in_acc && (in_cmd == CMD_REMEMBER);

  rais_ram #(.WIDTH(IDX_W), .DEPTH(D)) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_r),
    .wdata (in_idx),
    .raddr (rd_ptr_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
      fill_r <= '0;
    end else if (ram_we) begin
      slot_r <= (slot_r == AW'(D - 1)) ? '0 : slot_r + 1'b1;
      if (fill_r != FW'(D)) begin
        fill_r <= fill_r + 1'b1;
      end
    end
  end

  // sorted blocked list
  assign step_on = (state_r == S_STEP) && (lst_cnt != '0) &&
                   ({1'b0, lst_head} <= rank_r);

  always_comb begin
    lst_ctl.clear = in_acc && (in_cmd == CMD_CHOOSE);
    lst_ctl.ins   = (state_r == S_SCAN) && pend_r && (ram_rdata < count_r);
    lst_ctl.pop   = step_on;
  end

  rais_sort_list #(.DEPTH(D)) u_list (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (lst_ctl),
    .ins_value (ram_rdata),
    .head      (lst_head),
    .cnt       (lst_cnt)
  );

  // shared remainder unit
  assign seq_plus1 = {1'b0, ram_rdata} + 1'b1;
  assign div_start = (state_r == S_DIVGO);
  assign div_dvd   = shuffle_r ? roll_r : ROLL_W'(seq_plus1);
  assign div_dsr   = shuffle_r ? count_r - IDX_W'(lst_cnt) : count_r;

  rais_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (div_dsr),
    .busy      (div_busy),
    .done      (div_done),
    .remainder (div_rem)
  );

  // sequencer
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt  = state_r;
    rd_ptr_nxt = rd_ptr_r;
    left_nxt   = left_r;
    pend_nxt   = 1'b0;
    rank_nxt   = rank_r;
    res_nxt    = res_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_cmd == CMD_CHOOSE)) begin
          rd_ptr_nxt = slot_prev;
          left_nxt   = window;
          res_nxt    = '0;
          if (count_r <= 16'd1) begin
            state_nxt = S_DONE;
          end else if (!shuffle_r) begin
            state_nxt = (!hvalid_r || (fill_r == '0)) ? S_DONE : S_SEQ_RD;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SEQ_RD: begin
        state_nxt = S_DIVGO;
      end
      S_SCAN: begin
        if (left_r != '0) begin
          rd_ptr_nxt = ptr_prev;
          left_nxt   = left_r - 1'b1;
          pend_nxt   = 1'b1;
        end else if (!pend_r) begin
          state_nxt = S_DIVGO;
        end
      end
      S_DIVGO: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          rank_nxt  = {1'b0, div_rem};
          res_nxt   = div_rem;
          state_nxt = shuffle_r ? S_STEP : S_DONE;
        end
      end
      S_STEP: begin
        if (step_on) begin
          rank_nxt = rank_r + 1'b1;
        end else begin
          res_nxt   = (rank_r >= {1'b0, count_r}) ? cm1 : rank_r[IDX_W-1:0];
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pend_r  <= 1'b0;
      left_r  <= '0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      left_r  <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_ptr_r <= rd_ptr_nxt;
    rank_r   <= rank_nxt;
    res_r    <= res_nxt;
    if (in_acc) begin
      roll_r <= in_roll;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= res_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // checks
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(D))
    else $error("history fill above depth");

  a_list_bound: assert property (@(posedge clk) disable iff (!rst_n)
    lst_cnt <= fill_r)
    else $error("blocked list longer than history");

  a_div_owned: assert property (@(posedge clk) disable iff (!rst_n)
    div_busy |-> (state_r == S_DIV))
    else $error("divider running outside its state");

  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> (fill_r == FW'(D)) || (fill_r == $past(fill_r) + 1'b1))
    else $error("remember did not advance fill");

endmodule
`default_nettype wire
